[rtl/efla_pkg.sv]
// efla_pkg: shared types and codes for the extent free-list allocator.
// Used by efla_ctrl, efla_datapath and extent_free_list_allocator.
`timescale 1ns / 1ps
package efla_pkg;

  localparam int BLOCK_W = 10;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int VOL_W   = 11;

  localparam logic [VOL_W-1:0] VOL_RESET = 11'd1024;

  localparam logic [FUNC_W-1:0] FN_ALLOC  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_FORMAT = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_REFUSED = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [BLOCK_W-1:0] block;
  } in_word_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] granted_block;
    logic [STAT_W-1:0]  status;
    logic [BLOCK_W-1:0] free_count;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch input word, read head header
    logic commit;   // apply operation, load result register
    logic cfg_wr;   // write volume size
  } dp_cmd_t;

endpackage

[rtl/efla_ctrl.sv]
// efla_ctrl: sequencing FSM for the allocator (capture, then commit).
// Depends on efla_pkg for the command struct.
`timescale 1ns / 1ps
module efla_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  output efla_pkg::dp_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_comb begin
    cmd.capture = in_valid && (state == S_IDLE);
    cmd.commit  = (state == S_EXEC) && (!out_valid || !out_stall);
    cmd.cfg_wr  = cfg_valid && cfg_ready;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.capture) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) out_valid_next = 1'b1;
    else if (out_valid && !out_stall) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/efla_datapath.sv]
// efla_datapath: head/free-count registers, extent header memory, result register.
// Depends on efla_pkg for word types and codes.
`timescale 1ns / 1ps
module efla_datapath #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  efla_pkg::dp_cmd_t          cmd,
  input  efla_pkg::in_word_t         in_data,
  input  logic [efla_pkg::VOL_W-1:0] cfg_data,
  output efla_pkg::out_word_t        out_data
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int CW = (AW + 1 > efla_pkg::VOL_W) ? AW + 1 : efla_pkg::VOL_W;
  localparam int WW = (AW > efla_pkg::BLOCK_W) ? AW : efla_pkg::BLOCK_W;

  typedef struct packed {
    logic [AW-1:0] len;
    logic [AW-1:0] nxt;
  } hdr_t;

  hdr_t hdr_mem [NUM_BLOCKS];
  hdr_t rd_hdr;

  logic [efla_pkg::VOL_W-1:0] volume_blocks;
  logic [AW-1:0]              head;
  logic [AW-1:0]              head_next;
  logic [AW-1:0]              free_cnt;
  logic [AW-1:0]              free_cnt_next;
  efla_pkg::in_word_t         op;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  hdr_t                       wr_hdr;

  logic [CW-1:0]              vol_ext;
  logic [CW-1:0]              size;
  logic [CW-1:0]              blk_ext;
  logic [AW:0]                head_inc;
  logic [AW-1:0]              granted;
  logic [efla_pkg::STAT_W-1:0] stat;
  logic [WW-1:0]              granted_w;
  logic [WW-1:0]              free_w;

  // clamp volume size to 2..NUM_BLOCKS
  always_comb begin
    vol_ext = CW'(volume_blocks);
    if (vol_ext < CW'(2)) size = CW'(2);
    else if (vol_ext > CW'(NUM_BLOCKS)) size = CW'(NUM_BLOCKS);
    else size = vol_ext;
  end

  assign blk_ext  = CW'(op.block);
  assign head_inc = {1'b0, head} + (AW+1)'(1);

  always_comb begin
    head_next     = head;
    free_cnt_next = free_cnt;
    granted       = '0;
    stat          = efla_pkg::ST_OK;
    wr_en         = 1'b0;
    wr_addr       = head_inc[AW-1:0];
    wr_hdr        = '0;
    case (op.func)
      efla_pkg::FN_ALLOC: begin
        if (free_cnt == '0 || head == '0 || {1'b0, head} >= (AW+1)'(NUM_BLOCKS)) begin
          stat = efla_pkg::ST_FULL;
        end else begin
          granted = head;
          if (rd_hdr.len <= AW'(1) || head_inc >= (AW+1)'(NUM_BLOCKS)) begin
            head_next = rd_hdr.nxt;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = head_inc[AW-1:0];
            wr_hdr.len = rd_hdr.len - AW'(1);
            wr_hdr.nxt = rd_hdr.nxt;
            head_next  = head_inc[AW-1:0];
          end
          free_cnt_next = free_cnt - AW'(1);
        end
      end
      efla_pkg::FN_FREE: begin
        if (blk_ext == '0 || blk_ext >= size) begin
          stat = efla_pkg::ST_REFUSED;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = blk_ext[AW-1:0];
          wr_hdr.len = AW'(1);
          wr_hdr.nxt = head;
          head_next  = blk_ext[AW-1:0];
          if (free_cnt < AW'(NUM_BLOCKS - 1)) free_cnt_next = free_cnt + AW'(1);
        end
      end
      efla_pkg::FN_FORMAT: begin
        head_next     = AW'(1);
        free_cnt_next = AW'(size - CW'(1));
        wr_en         = 1'b1;
        wr_addr       = AW'(1);
        wr_hdr.len    = AW'(size - CW'(1));
        wr_hdr.nxt    = '0;
      end
      default: begin
      end
    endcase
  end

  assign granted_w = WW'(granted);
  assign free_w    = WW'(free_cnt_next);

  // header memory: one read port (at capture), one write port (at commit)
  always_ff @(posedge clk) begin
    if (cmd.capture) rd_hdr <= hdr_mem[head];
    if (cmd.commit && wr_en) hdr_mem[wr_addr] <= wr_hdr;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) op <= in_data;
    if (cmd.commit) begin
      out_data.granted_block <= granted_w[efla_pkg::BLOCK_W-1:0];
      out_data.status        <= stat;
      out_data.free_count    <= free_w[efla_pkg::BLOCK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_blocks <= efla_pkg::VOL_RESET;
      head          <= '0;
      free_cnt      <= '0;
    end else begin
      if (cmd.cfg_wr) volume_blocks <= cfg_data;
      if (cmd.commit) begin
        head     <= head_next;
        free_cnt <= free_cnt_next;
      end
    end
  end

endmodule

[rtl/extent_free_list_allocator.sv]
// extent_free_list_allocator: top level, joins controller and datapath.
// Depends on efla_pkg, efla_ctrl and efla_datapath.
`timescale 1ns / 1ps
// Block allocator for one volume of NUM_BLOCKS blocks; block 0 is the
// superblock and never handed out. Free blocks sit on a list of extents whose
// headers (length, next) live in an on-chip header memory, one entry per
// block. When a word is accepted, the head extent's header is read from the
// memory's registered read port; then, in the exec state, the block
// computes the outcome, writes the moved or new header through the single
// write port and loads the result register. A new word is accepted as soon as
// the previous one has committed, even while its result still waits on a
// stalled output; a stall on the output holds the block only when a second
// result is ready behind it. Headers are undefined after reset (there is no
// clearing pass): format the volume before allocating. The volume size
// register may be written while the block is idle (cfg_ready high); values
// outside 2..NUM_BLOCKS are clamped.
module extent_free_list_allocator #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  efla_pkg::in_word_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output efla_pkg::out_word_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [efla_pkg::VOL_W-1:0] cfg_data
);

  efla_pkg::dp_cmd_t cmd;

  // sequencing: idle -> exec, result valid flag
  efla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // list state, header memory and result register
  efla_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

  // an accepted word occupies the block for the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // a result appears only from a commit
  a_valid_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result valid without commit");

  // commit never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

  // failed operations grant nothing
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != efla_pkg::ST_OK) |-> (out_data.granted_block == '0))
    else $error("block granted on failed operation");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for extent_free_list_allocator.
// Needs efla_pkg and the allocator RTL. It predicts every result word,
// drives directed and random traffic, with random idling on both sides in most phases, and checks each field.
module testbench;
  import efla_pkg::*;

  localparam int NUM_BLOCKS  = 1024;
  localparam int PHASE_ITEMS = 220;
  localparam int NUM_PHASES  = 9;
  // func code with no operation behind it
  localparam logic [FUNC_W-1:0] FN_UNKNOWN = 2'd3;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_word_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [VOL_W-1:0]   cfg_data  = '0;

  // volume size per phase: minimum, clamped low and high, maximum, in between
  logic [VOL_W-1:0] vol_plan [NUM_PHASES] =
    '{11'd2, 11'd0, 11'd1024, 11'd2047, 11'd1, 11'd3, 11'd17, 11'd1024, 11'd300};

  // shadow of the allocator state
  logic [VOL_W-1:0]   vol_reg = VOL_RESET;
  logic [BLOCK_W-1:0] head_q  = '0;
  logic [BLOCK_W-1:0] free_q  = '0;
  bit   [BLOCK_W-1:0] hdr_len  [NUM_BLOCKS];
  bit   [BLOCK_W-1:0] hdr_next [NUM_BLOCKS];
  logic [BLOCK_W-1:0] held_blocks [$];   // granted blocks, candidates for a clean free

  in_word_t  pending_words  [$];
  out_word_t expected_words [$];

  logic in_fired = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   n_errors  = 0;
  int   n_results = 0;
  int   n_grants  = 0;
  int   n_full    = 0;
  int   n_refused = 0;

  extent_free_list_allocator #(.NUM_BLOCKS(NUM_BLOCKS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int volume_size();
    int s;
    s = vol_reg;
    if (s < 2) s = 2;
    if (s > NUM_BLOCKS) s = NUM_BLOCKS;
    return s;
  endfunction

  // Apply one word to the shadow state, return the result word it should give.
  function automatic out_word_t apply_op(in_word_t w);
    out_word_t r;
    int size;
    int h;
    int len;
    int nxt;
    size = volume_size();
    r = '0;
    r.status = ST_OK;
    case (w.func)
      FN_ALLOC: begin
        if (free_q == 0 || head_q == 0) begin
          r.status = ST_FULL;
        end else begin
          h   = head_q;
          len = hdr_len[h];
          nxt = hdr_next[h];
          r.granted_block = BLOCK_W'(h);
          // one-block extent (or no room behind it): unlink, else slide header up
          if (len <= 1 || h + 1 >= NUM_BLOCKS) begin
            head_q = BLOCK_W'(nxt);
          end else begin
            hdr_len[h+1]  = BLOCK_W'(len - 1);
            hdr_next[h+1] = BLOCK_W'(nxt);
            head_q = BLOCK_W'(h + 1);
          end
          free_q = free_q - 1'b1;
          held_blocks.push_back(BLOCK_W'(h));
        end
      end
      FN_FREE: begin
        if (w.block == 0 || int'(w.block) >= size) begin
          r.status = ST_REFUSED;
        end else begin
          hdr_len[w.block]  = BLOCK_W'(1);
          hdr_next[w.block] = head_q;
          head_q = w.block;
          if (free_q < NUM_BLOCKS - 1) free_q = free_q + 1'b1;
        end
      end
      FN_FORMAT: begin
        head_q = BLOCK_W'(1);
        free_q = BLOCK_W'(size - 1);
        hdr_len[1]  = BLOCK_W'(size - 1);
        hdr_next[1] = '0;
        held_blocks.delete();
      end
      default: ;
    endcase
    r.free_count = free_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    if (n_errors <= 40)
      $display("%0t ns mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Monitor: checks result words, feeds accepted words and register writes to the shadow.
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      in_fired <= 1'b0;
      vol_reg = VOL_RESET;
      head_q  = '0;
      free_q  = '0;
    end else begin
      in_fired <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("result word with none expected",
                          int'(out_data.granted_block), 0);
        end else begin
          want = expected_words.pop_front();
          n_results++;
          if (out_data.granted_block !== want.granted_block)
            report_mismatch("granted_block", int'(out_data.granted_block),
                            int'(want.granted_block));
          if (out_data.status !== want.status)
            report_mismatch("status", int'(out_data.status), int'(want.status));
          if (out_data.free_count !== want.free_count)
            report_mismatch("free_count", int'(out_data.free_count),
                            int'(want.free_count));
          if (want.granted_block != 0) n_grants++;
          if (want.status == ST_FULL) n_full++;
          if (want.status == ST_REFUSED) n_refused++;
        end
      end
      if (cfg_valid && cfg_ready) vol_reg = cfg_data;
      if (in_valid && !in_stall) expected_words.push_back(apply_op(in_data));
    end
  end

  // Sender: next word goes out once the current one is taken; a held word stays put.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else     out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic queue_word(input logic [FUNC_W-1:0] f, input int b);
    in_word_t w;
    while (pending_words.size() >= 3) @(negedge clk);
    w.func  = f;
    w.block = BLOCK_W'(b);
    pending_words.push_back(w);
  endtask

  // Wait until every word went out and every result came back (bounded by a timeout).
  task automatic drain();
    int waited;
    waited = 0;
    while ((pending_words.size() != 0 || in_valid || expected_words.size() != 0)
           && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_volume(input logic [VOL_W-1:0] v);
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly format-then-use traffic: allocates, frees of granted blocks;
  // the rest is double frees, out of range frees, formats and unknown codes.
  task automatic run_random_phase(input bit with_pause);
    int alloc_pct;
    int r;
    int size;
    int k;
    int b;
    alloc_pct = $urandom_range(65, 35);
    queue_word(FN_FORMAT, $urandom_range(1023));
    for (int i = 1; i < PHASE_ITEMS; i++) begin
      if (with_pause && i == PHASE_ITEMS / 2) drain();
      size = volume_size();
      r = $urandom_range(99);
      if (r < 2) begin
        queue_word(FN_UNKNOWN, $urandom_range(1023));
      end else if (r < 5) begin
        queue_word(FN_FORMAT, $urandom_range(1023));
      end else if (r < 5 + alloc_pct) begin
        queue_word(FN_ALLOC, $urandom_range(1023));
      end else begin
        r = $urandom_range(99);
        if (r < 70 && held_blocks.size() != 0) begin
          k = $urandom_range(held_blocks.size() - 1);
          b = held_blocks[k];
          held_blocks.delete(k);
          queue_word(FN_FREE, b);
        end else if (r < 85) begin
          queue_word(FN_FREE, $urandom_range(size - 1, 1));
        end else begin
          queue_word(FN_FREE, $urandom_range(1023));
        end
      end
    end
  endtask

  initial begin
    send_idle_pct = 22;
    recv_idle_pct = 47;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full-size volume straight from reset, list empty until formatted
    queue_word(FN_ALLOC, 1023);     // empty list
    queue_word(FN_UNKNOWN, 1023);
    queue_word(FN_FREE, 0);         // superblock refused
    queue_word(FN_FREE, 1023);      // top block onto an empty list
    queue_word(FN_ALLOC, 0);
    queue_word(FN_ALLOC, 0);        // empty again
    queue_word(FN_FORMAT, 1023);
    queue_word(FN_ALLOC, 0);        // header slides to block 2
    queue_word(FN_ALLOC, 0);
    queue_word(FN_FREE, 1);
    queue_word(FN_FREE, 7);         // double free of a block inside the extent; count reaches the top
    queue_word(FN_FREE, 9);         // count saturates
    queue_word(FN_FREE, 11);        // count stays saturated
    queue_word(FN_ALLOC, 0);        // one-block extent unlinked
    queue_word(FN_UNKNOWN, 0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 22;
      end
      if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_volume(vol_plan[p]);
      if (p == 0) begin
        // smallest volume: one usable block
        queue_word(FN_FORMAT, 0);
        queue_word(FN_FREE, 2);     // at the volume size
        queue_word(FN_FREE, 1023);
        queue_word(FN_ALLOC, 0);
        queue_word(FN_ALLOC, 0);
        queue_word(FN_FREE, 1);
        queue_word(FN_FREE, 1);
        queue_word(FN_ALLOC, 0);
        queue_word(FN_ALLOC, 0);
        queue_word(FN_ALLOC, 0);
      end
      run_random_phase(p == 4 || p == 7);
      drain();
    end

    if (expected_words.size() != 0)
      report_mismatch("results never delivered", expected_words.size(), 0);
    $display("Checked %0d result words over %0d volume settings, idling on either side or none.",
             n_results, NUM_PHASES + 1);
    $display("%0d grants, %0d allocates on an empty list, %0d refused frees.",
             n_grants, n_full, n_refused);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
